// ===== sv/ordered_sum_composition_count_defines.svh =====
// ----------------------------------------------------------------------------
// ordered sum composition count assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_SUM_COMPOSITION_COUNT_DEFINES_SVH
`define ORDERED_SUM_COMPOSITION_COUNT_DEFINES_SVH

// property checked outside reset
`define OSCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define OSCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/oscc_pkg.sv =====
// ----------------------------------------------------------------------------
// ordered sum composition count package
// fixed field widths shared by the block and its checker
// ----------------------------------------------------------------------------
package oscc_pkg;

   localparam int PART_WIDTH   = 10;
   localparam int TARGET_WIDTH = 10;
   localparam int RESULT_WIDTH = 32;

endpackage

// ===== sv/ordered_sum_composition_count.sv =====
// ----------------------------------------------------------------------------
// ordered sum composition count
// counts ordered compositions of a target sum from a loaded set of parts
// ----------------------------------------------------------------------------
// Usage: csr_wr_en/csr_wr_data set the target sum while the block is idle.
// Parts arrive on the req_ channel (valid/ready), one request per cycle while
// req_ready is high, and are kept in a part memory; a part beyond MAX_PARTS
// is dropped. The request with req_is_last set ends the set and starts the count.
// The count walks the sums 1..goal with one shared adder: for every sum the
// parts are streamed through a three-stage read/add path (part memory read,
// ways table read, accumulate), then the total is written back to the table.
// The goal is the target sum clipped to MAX_SUM - 1.
// req_ready is low from the last request until the result is placed in the
// rsp_ output register. A stalled receiver holds rsp_valid and the count;
// the next set may load meanwhile, and its result waits for the slot.
// Reset (synchronous) empties the set, clears the target to zero and drops
// any pending result; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_sum_composition_count #(
   parameter int MAX_PARTS   = 256,
   parameter int MAX_SUM     = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [oscc_pkg::TARGET_WIDTH-1:0]    csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [oscc_pkg::PART_WIDTH-1:0]      req_part_value,
   input  logic                                 req_is_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [oscc_pkg::RESULT_WIDTH-1:0]    rsp_way_count
);

   localparam int SUM_W = $clog2(MAX_SUM);
   localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTS + 1);
   localparam int CMP_W = (SUM_W > oscc_pkg::PART_WIDTH) ? SUM_W : oscc_pkg::PART_WIDTH;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FETCH = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic [oscc_pkg::TARGET_WIDTH-1:0]   target_ff;
   logic [SUM_W-1:0]                    goal_ff, goal_in;
   logic [SUM_W-1:0]                    sum_ff, sum_in;
   logic [CNT_W-1:0]                    pidx_ff, pidx_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [COUNT_WIDTH-1:0]              acc_ff, acc_in;
   logic                                v1_ff, v1_in;
   logic                                v2_ff, v2_in;
   logic                                use2_ff, use2_in;
   logic                                zero2_ff, zero2_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [oscc_pkg::RESULT_WIDTH-1:0]   rsp_count_ff, rsp_count_in;

   logic [oscc_pkg::PART_WIDTH-1:0]     part_mem [MAX_PARTS];
   logic [COUNT_WIDTH-1:0]              ways_mem [MAX_SUM];
   logic [oscc_pkg::PART_WIDTH-1:0]     part_q_ff;
   logic [COUNT_WIDTH-1:0]              ways_q_ff;

   logic                                part_we;
   logic                                ways_we;
   logic [SUM_W-1:0]                    ways_waddr;
   logic [COUNT_WIDTH-1:0]              ways_wdata;
   logic [SUM_W-1:0]                    ways_raddr;
   logic [CMP_W-1:0]                    part_ext;
   logic [CMP_W-1:0]                    sum_ext;
   logic [63:0]                         ways_wide;

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_way_count = rsp_count_ff;

   // stage b: part known, form the table address
   assign part_ext  = CMP_W'(part_q_ff);
   assign sum_ext   = CMP_W'(sum_ff);
   assign ways_wide = 64'(ways_q_ff);

   always_comb begin
      if ((state_ff == ST_FETCH) || (state_ff == ST_OUT)) begin
         ways_raddr = goal_ff;
      end else begin
         ways_raddr = SUM_W'(sum_ext - part_ext);
      end
   end

   always_comb begin
      state_in     = state_ff;
      goal_in      = goal_ff;
      sum_in       = sum_ff;
      pidx_in      = pidx_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      v1_in        = 1'b0;
      v2_in        = v1_ff;
      use2_in      = (part_ext <= sum_ext);
      zero2_in     = (part_q_ff == '0);
      part_we      = 1'b0;
      ways_we      = 1'b0;
      ways_waddr   = sum_ff;
      ways_wdata   = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;

      // stage c: accumulate, a zero part doubles the partial total
      if (v2_ff && use2_ff) begin
         acc_in = acc_ff + (zero2_ff ? acc_ff : ways_q_ff);
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_PARTS)) begin
                  part_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_is_last) begin
                  if (32'(target_ff) >= 32'(MAX_SUM)) begin
                     goal_in = SUM_W'(MAX_SUM - 1);
                  end else begin
                     goal_in = SUM_W'(target_ff);
                  end
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            ways_we    = 1'b1;
            ways_waddr = '0;
            ways_wdata = COUNT_WIDTH'(1);
            sum_in     = SUM_W'(1);
            pidx_in    = '0;
            acc_in     = '0;
            if (goal_ff == '0) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (pidx_ff < count_ff) begin
               v1_in   = 1'b1;
               pidx_in = pidx_ff + CNT_W'(1);
            end
            if ((pidx_ff + CNT_W'(1)) >= count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               ways_we = 1'b1;
               acc_in  = '0;
               pidx_in = '0;
               if (sum_ff == goal_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  sum_in   = sum_ff + SUM_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FETCH: begin
            count_in = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = ways_wide[oscc_pkg::RESULT_WIDTH-1:0];
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         target_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         pidx_ff      <= '0;
         acc_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         pidx_ff      <= pidx_in;
         acc_ff       <= acc_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      goal_ff      <= goal_in;
      use2_ff      <= use2_in;
      zero2_ff     <= zero2_in;
      rsp_count_ff <= rsp_count_in;
   end

   // part memory
   always_ff @(posedge clock) begin
      if (part_we) begin
         part_mem[count_ff[IDX_W-1:0]] <= req_part_value;
      end
      part_q_ff <= part_mem[pidx_ff[IDX_W-1:0]];
   end

   // ways table
   always_ff @(posedge clock) begin
      if (ways_we) begin
         ways_mem[ways_waddr] <= ways_wdata;
      end
      ways_q_ff <= ways_mem[ways_raddr];
   end

endmodule

// ===== sv/oscc_checker.sv =====
// ----------------------------------------------------------------------------
// ordered sum composition count checker
// port level properties of the request and response channels
// ----------------------------------------------------------------------------
`include "ordered_sum_composition_count_defines.svh"

module oscc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_is_last,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [oscc_pkg::RESULT_WIDTH-1:0]   rsp_way_count
);

   `OSCC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `OSCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_way_count), "stalled response changed")
   `OSCC_ASSERT(a_part_keeps_ready, clock, reset, req_valid && req_ready && !req_is_last |=> req_ready, "not ready after a part")
   `OSCC_ASSERT(a_last_drops_ready, clock, reset, req_valid && req_ready && req_is_last |=> !req_ready, "ready right after last part")

endmodule

bind ordered_sum_composition_count oscc_checker u_oscc_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered sum composition count testbench
// loads part sets over the request channel under a range of target sums and
// compares every way count with a local dynamic-programming count of the
// ordered compositions or a known value, with random gaps on both channels, a long
// receiver hold that backs up the request side, and a set that overflows the
// part store
module tb;

   localparam int PART_SLOTS    = 256;
   localparam int TABLE_DEPTH   = 1024;
   localparam int ITEM_TARGET   = 700;
   localparam int QUIET_FROM    = 620;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX    = 10;
   localparam int OVERFLOW_SET  = 260;

   typedef logic [oscc_pkg::PART_WIDTH-1:0]   part_type;
   typedef logic [oscc_pkg::TARGET_WIDTH-1:0] goal_type;
   typedef logic [oscc_pkg::RESULT_WIDTH-1:0] count_type;

   typedef struct packed {
      bit        wr;
      goal_type  goal;
      part_type  part;
      bit        last;
      bit        known;
      count_type want;
   } opening_row_type;

   typedef struct {
      count_type count;
      int        set_no;
   } due_type;

   localparam opening_row_type OPENING [17] = '{
      '{1'b0, 10'd0,    10'd7,    1'b1, 1'b1, 32'd1},
      '{1'b1, 10'd1,    10'd0,    1'b1, 1'b1, 32'd0},
      '{1'b0, 10'd1,    10'd1,    1'b1, 1'b1, 32'd1},
      '{1'b1, 10'd4,    10'd1,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd4,    10'd2,    1'b1, 1'b0, 32'd0},
      '{1'b0, 10'd4,    10'd1,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd4,    10'd0,    1'b1, 1'b0, 32'd0},
      '{1'b1, 10'd1023, 10'd1023, 1'b1, 1'b1, 32'd1},
      '{1'b0, 10'd1023, 10'd1,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd1023, 10'd2,    1'b1, 1'b0, 32'd0},
      '{1'b1, 10'd10,   10'd11,   1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd10,   10'd1023, 1'b1, 1'b1, 32'd0},
      '{1'b1, 10'd5,    10'd5,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd5,    10'd1,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd5,    10'd5,    1'b1, 1'b0, 32'd0},
      '{1'b1, 10'd0,    10'd3,    1'b0, 1'b0, 32'd0},
      '{1'b0, 10'd0,    10'd0,    1'b1, 1'b1, 32'd1}
   };

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      csr_wr_en      = 1'b0;
   goal_type  csr_wr_data    = '0;
   logic      req_valid      = 1'b0;
   logic      req_ready;
   part_type  req_part_value = '0;
   logic      req_is_last    = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready      = 1'b0;
   count_type rsp_way_count;

   part_type  held_parts [PART_SLOTS];
   int        held_count = 0;
   count_type ways_memo [TABLE_DEPTH];
   goal_type  goal_now = '0;
   due_type   ways_due [$];
   due_type   taken;

   bit     gaps_on   = 1'b1;
   bit     hold_ask  = 1'b0;
   int     hold_count;
   int     items_sent   = 0;
   int     sets_sent    = 0;
   int     results_seen = 0;
   int     fails        = 0;

   ordered_sum_composition_count dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_part_value (req_part_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_way_count  (rsp_way_count)
   );

   always #6 clock = ~clock;

   // ways(s) built up from ways(0) = 1; a zero part doubles the running sum
   function automatic count_type compositions_of(goal_type goal);
      count_type acc;
      int        s;
      int        k;
      ways_memo[0] = 1;
      for (s = 1; s <= goal; s++) begin
         acc = '0;
         for (k = 0; k < held_count; k++) begin
            if (held_parts[k] <= s) begin
               acc = acc + ((held_parts[k] == 0) ? acc : ways_memo[s - held_parts[k]]);
            end
         end
         ways_memo[s] = acc;
      end
      return ways_memo[goal];
   endfunction

   function automatic part_type pick_part(goal_type g);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r <= 6) return part_type'($urandom_range(1, (g < 2) ? 2 : g));
      return part_type'($urandom_range(0, 1023));
   endfunction

   task automatic offer_part(part_type part, bit last, bit known, count_type want);
      count_type predicted;
      due_type   entry;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_part_value <= part;
      req_is_last    <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      // a full store drops the part but still honours the last flag
      if (held_count < PART_SLOTS) begin
         held_parts[held_count] = part;
         held_count++;
      end
      if (last) begin
         predicted    = compositions_of(goal_now);
         entry.count  = known ? want : predicted;
         entry.set_no = sets_sent;
         ways_due.insert(ways_due.size(), entry);
         sets_sent++;
         held_count = 0;
      end
   endtask

   task automatic gap(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic set_goal(goal_type g);
      @(negedge clock);
      req_valid <= 1'b0;
      while (ways_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      goal_now = g;
   endtask

   task automatic random_set(goal_type g, int n);
      int k;
      for (k = 0; k < n; k++) begin
         if (gaps_on && $urandom_range(0, 3) == 0) gap($urandom_range(1, 3));
         offer_part(pick_part(g), k == n - 1, 1'b0, '0);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (ways_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
               $display("unexpected result: way_count %0d", rsp_way_count);
         end else begin
            taken = ways_due.pop_front();
            results_seen++;
            if (rsp_way_count !== taken.count) begin
               fails++;
               if (fails <= REPORT_MAX)
                  $display("set %0d: way_count expected %0d, got %0d",
                           taken.set_no, taken.count, rsp_way_count);
            end
         end
      end
   end

   // result side: random stalls plus one long hold on request
   initial begin
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // request side
   initial begin
      int          phase;
      int          k;
      goal_type    g;
      int unsigned r;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING[i]) begin
         if (OPENING[i].wr) set_goal(OPENING[i].goal);
         if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 3));
         offer_part(OPENING[i].part, OPENING[i].last, OPENING[i].known, OPENING[i].want);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
         else gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 4) begin
            // receiver held off while short sets keep coming
            set_goal(10'd6);
            gaps_on = 1'b0;
            @(posedge clock);
            hold_ask = 1'b1;
            repeat (10) random_set(10'd6, 3);
         end else if (phase == 9) begin
            // more parts than the store holds; the trailing ones must be dropped
            set_goal(10'd5);
            for (k = 0; k < OVERFLOW_SET; k++)
               offer_part((k < PART_SLOTS) ? part_type'($urandom_range(2, 1023)) :
                                             part_type'(1),
                          k == OVERFLOW_SET - 1, 1'b0, '0);
         end else begin
            r = $urandom_range(0, 11);
            if (r == 0) g = 10'd1023;
            else if (r == 1) g = goal_type'($urandom_range(100, 1022));
            else if (r == 2) g = '0;
            else g = goal_type'($urandom_range(1, 40));
            set_goal(g);
            if (g > 100) random_set(g, $urandom_range(1, 3));
            else repeat ($urandom_range(1, 4)) random_set(g, $urandom_range(1, 8));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (ways_due.size() != 0) @(negedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("%0d part requests in %0d sets, %0d way counts compared, %0d mismatches",
               items_sent, sets_sent, results_seen, fails);
      $display("targets 0 to 1023, zero parts, store overflow and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #120000000;
      $display("timeout: %0d way counts still outstanding", ways_due.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
